// ----- rtl/core/jsl_pkg.sv -----
// jsl_pkg: constants, result types and byte-class helpers for the streaming JSON lexer.
// Standalone; used by the lexer top level and its checker.
package jsl_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int LIM_W       = 9;

   localparam logic [4:0] ST_SUCCESS       = 5'd0;
   localparam logic [4:0] ST_FAILURE       = 5'd1;
   localparam logic [4:0] ST_RETRY         = 5'd2;
   localparam logic [4:0] ST_NO_DATA       = 5'd3;
   localparam logic [4:0] ST_OVERFLOW      = 5'd4;
   localparam logic [4:0] ST_UNDERFLOW     = 5'd5;
   localparam logic [4:0] ST_EXP_COLON     = 5'd6;
   localparam logic [4:0] ST_EXP_COMMA     = 5'd7;
   localparam logic [4:0] ST_EXP_DECIMAL   = 5'd9;
   localparam logic [4:0] ST_EXP_DIGIT     = 5'd10;
   localparam logic [4:0] ST_EXP_HEX       = 5'd12;
   localparam logic [4:0] ST_EXP_LITERAL   = 5'd13;
   localparam logic [4:0] ST_EXP_PRINTABLE = 5'd14;
   localparam logic [4:0] ST_EXP_QUOTE     = 5'd15;
   localparam logic [4:0] ST_EXP_ESCAPE    = 5'd16;
   localparam logic [4:0] ST_EXP_UTF16_HI  = 5'd17;
   localparam logic [4:0] ST_EXP_UTF16_LO  = 5'd18;
   localparam logic [4:0] ST_EXP_UTF8      = 5'd19;
   localparam logic [4:0] ST_EXP_VALUE     = 5'd20;

   localparam logic [2:0] EV_NOTHING    = 3'd0;
   localparam logic [2:0] EV_START      = 3'd1;
   localparam logic [2:0] EV_END        = 3'd2;
   localparam logic [2:0] EV_DOUBLE_END = 3'd3;
   localparam logic [2:0] EV_BYTES      = 3'd4;

   localparam logic [2:0] K_NONE    = 3'd0;
   localparam logic [2:0] K_OBJECT  = 3'd1;
   localparam logic [2:0] K_ARRAY   = 3'd2;
   localparam logic [2:0] K_STRING  = 3'd3;
   localparam logic [2:0] K_NUMBER  = 3'd4;
   localparam logic [2:0] K_LITERAL = 3'd5;

   localparam logic [3:0] F_FIRST     = 4'd1;
   localparam logic [3:0] F_ELEMENT   = 4'd2;
   localparam logic [3:0] F_MEM_NAME  = 4'd4;
   localparam logic [3:0] F_MEM_VALUE = 4'd8;

   localparam logic [4:0] S_START         = 5'd0;
   localparam logic [4:0] S_ELEM_FIRST    = 5'd1;
   localparam logic [4:0] S_ELEM_SEP      = 5'd2;
   localparam logic [4:0] S_ELEM_NEXT     = 5'd3;
   localparam logic [4:0] S_NAME_FIRST    = 5'd4;
   localparam logic [4:0] S_NAME_SEP      = 5'd5;
   localparam logic [4:0] S_VALUE_START   = 5'd6;
   localparam logic [4:0] S_MEM_SEP       = 5'd7;
   localparam logic [4:0] S_MEM_NEXT      = 5'd8;
   localparam logic [4:0] S_STR           = 5'd9;
   localparam logic [4:0] S_STR_ESC       = 5'd10;
   localparam logic [4:0] S_STR_HEX       = 5'd11;
   localparam logic [4:0] S_STR_LO        = 5'd12;
   localparam logic [4:0] S_INT_START     = 5'd13;
   localparam logic [4:0] S_INT_CONT      = 5'd14;
   localparam logic [4:0] S_INT_END       = 5'd15;
   localparam logic [4:0] S_FRAC_START    = 5'd16;
   localparam logic [4:0] S_FRAC_CONT     = 5'd17;
   localparam logic [4:0] S_EXP_START     = 5'd18;
   localparam logic [4:0] S_EXP_INT_START = 5'd19;
   localparam logic [4:0] S_EXP_INT_CONT  = 5'd20;
   localparam logic [4:0] S_FALSE         = 5'd21;
   localparam logic [4:0] S_NULL          = 5'd22;
   localparam logic [4:0] S_TRUE          = 5'd23;

   localparam logic [31:0] NUM_END_MASK = 32'h0012_C000;

   typedef struct packed {
      logic [4:0]  status;
      logic [2:0]  event_res;
      logic [2:0]  kind;
      logic [3:0]  flags;
      logic        has_bytes;
      logic [2:0]  byte_count;
      logic [31:0] out_bytes;
   } res_type;

   typedef struct packed {
      logic       ok;
      logic [2:0] kind;
      logic [3:0] flags;
      logic [4:0] state;
      logic [7:0] first;
   } eat_type;

   function automatic res_type mk_res(input logic [4:0] status, input logic [2:0] ev,
                                      input logic [2:0] kind, input logic [3:0] flags,
                                      input logic has, input logic [2:0] cnt,
                                      input logic [31:0] bytes);
      res_type r;
      r.status = status;
      r.event_res = ev;
      r.kind = kind;
      r.flags = flags;
      r.has_bytes = has;
      r.byte_count = cnt;
      r.out_bytes = bytes;
      return r;
   endfunction

   function automatic res_type nothing(input logic [4:0] status);
      return mk_res(status, EV_NOTHING, K_NONE, 4'd0, 1'b0, 3'd0, 32'd0);
   endfunction

   function automatic res_type one_byte(input logic [7:0] c);
      return mk_res(ST_SUCCESS, EV_BYTES, K_NONE, 4'd0, 1'b1, 3'd1, {24'd0, c});
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dig(c) || ((c >= "A") && (c <= "F")) || ((c >= "a") && (c <= "f"));
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || (c == " ");
   endfunction

   function automatic logic is_num_end(input logic [7:0] c);
      return is_ws(c) || (c == ",") || (c == "]") || (c == "}");
   endfunction

   function automatic logic [3:0] nibble(input logic [7:0] c);
      logic [7:0] v;
      if (is_dig(c)) v = c - "0";
      else if ((c >= "A") && (c <= "F")) v = c - "A" + 8'd10;
      else v = c - "a" + 8'd10;
      return v[3:0];
   endfunction

   function automatic res_type utf8_out(input logic [31:0] cp);
      res_type r;
      r = mk_res(ST_SUCCESS, EV_BYTES, K_STRING, 4'd0, 1'b1, 3'd0, 32'd0);
      if (cp < 32'h80) begin
         r.byte_count = 3'd1;
         r.out_bytes = cp;
      end else if (cp < 32'h800) begin
         r.byte_count = 3'd2;
         r.out_bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      end else if (cp < 32'h10000) begin
         r.byte_count = 3'd3;
         r.out_bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      end else if (cp < 32'h110000) begin
         r.byte_count = 3'd4;
         r.out_bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                        5'b11110, cp[20:18]};
      end else begin
         r = nothing(ST_EXP_UTF8);
      end
      return r;
   endfunction

   // value opener: what to push for a byte that may start a value
   function automatic eat_type value_open(input logic [7:0] c, input logic [3:0] pf);
      eat_type e;
      e.ok = 1'b1;
      e.kind = K_NUMBER;
      e.flags = pf;
      e.state = S_INT_CONT;
      e.first = c;
      priority if (c == 8'h22) begin
         e.kind = K_STRING; e.state = S_STR; e.first = 8'd0;
      end else if (c == "-") begin
         e.state = S_INT_START;
      end else if (c == "0") begin
         e.state = S_INT_END;
      end else if (c == "[") begin
         e.kind = K_ARRAY; e.flags = F_FIRST; e.state = S_ELEM_FIRST; e.first = 8'd0;
      end else if (c == "{") begin
         e.kind = K_OBJECT; e.flags = F_FIRST; e.state = S_NAME_FIRST; e.first = 8'd0;
      end else if (c == "f") begin
         e.kind = K_LITERAL; e.state = S_FALSE;
      end else if (c == "n") begin
         e.kind = K_LITERAL; e.state = S_NULL;
      end else if (c == "t") begin
         e.kind = K_LITERAL; e.state = S_TRUE;
      end else begin
         e.ok = is_dig(c);
      end
      return e;
   endfunction

   function automatic logic [3:0] lit_len(input logic [1:0] w);
      return (w == 2'd0) ? 4'd5 : 4'd4;
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [3:0] idx);
      logic [7:0] ch;
      ch = 8'd0;
      unique case (w)
         2'd0: begin
            unique case (idx)
               4'd0: ch = "f";
               4'd1: ch = "a";
               4'd2: ch = "l";
               4'd3: ch = "s";
               4'd4: ch = "e";
               default: ch = 8'd0;
            endcase
         end
         2'd1: begin
            unique case (idx)
               4'd0: ch = "n";
               4'd1: ch = "u";
               4'd2: ch = "l";
               4'd3: ch = "l";
               default: ch = 8'd0;
            endcase
         end
         default: begin
            unique case (idx)
               4'd0: ch = "t";
               4'd1: ch = "r";
               4'd2: ch = "u";
               4'd3: ch = "e";
               default: ch = 8'd0;
            endcase
         end
      endcase
      return ch;
   endfunction

endpackage

// ----- rtl/core/jsl_req_if.sv -----
// jsl_req_if: input channel of the JSON lexer, one text byte or end mark per word.
// No dependencies.
interface jsl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;
   modport source (output valid, in_byte, end_of_input, input ready);
   modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

// ----- rtl/core/jsl_rsp_if.sv -----
// jsl_rsp_if: result channel of the JSON lexer, one event per word.
// No dependencies.
interface jsl_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  status;
   logic [2:0]  event_res;
   logic [2:0]  kind;
   logic        is_first;
   logic        is_element;
   logic        is_member_name;
   logic        is_member_value;
   logic        has_bytes;
   logic [2:0]  byte_count;
   logic [31:0] out_bytes;
   modport source (output valid, status, event_res, kind, is_first, is_element,
                   is_member_name, is_member_value, has_bytes, byte_count, out_bytes,
                   input ready);
   modport sink (input valid, status, event_res, kind, is_first, is_element,
                 is_member_name, is_member_value, has_bytes, byte_count, out_bytes,
                 output ready);
endinterface

// ----- rtl/core/jsl_csr_if.sv -----
// jsl_csr_if: register write channel of the JSON lexer (depth limit).
// No dependencies.
interface jsl_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/jsl_ram.sv -----
// jsl_ram: generic RAM, one write port, two registered read ports, write-first.
// No dependencies.
module jsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
      rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
   end
endmodule

// ----- rtl/core/json_stream_lexer.sv -----
// An accepted word passes the input register, then the result register; a number terminator
// is reprocessed in the same cycle. Throughput: one word per cycle unless the result stalls.
// The top frame lives in a register; frames below sit in a two-read RAM that is read
// one and two entries under the next top, so a double pop finds its frame ready.
// Reset (synchronous, active high): empty stack at the start state, depth limit 64.
// Depends on jsl_pkg, jsl_*_if and jsl_ram.
module json_stream_lexer (
   input logic         clock,
   input logic         reset,
   jsl_req_if.sink     req_if,
   jsl_rsp_if.source   rsp_if,
   jsl_csr_if.sink     csr_if
);
   import jsl_pkg::*;

   typedef struct packed {
      res_type             res;
      logic [STACK_AW-1:0] top;
      logic [4:0]          st;
      logic [31:0]         hex;
      logic [3:0]          wlen;
      logic [3:0]          pf;
      logic                push;
      logic [4:0]          parent;
   } step_type;

   function automatic step_type lex_step(input logic [7:0] c, input logic eoi,
                                         input logic [STACK_AW-1:0] top,
                                         input logic [4:0] st, input logic [4:0] below,
                                         input logic [31:0] hex, input logic [3:0] wlen,
                                         input logic [3:0] pf, input logic [LIM_W-1:0] limit);
      step_type   s;
      eat_type    e;
      logic       want_eat;
      logic       push_req;
      logic       pop_req;
      logic [2:0] pk;
      logic [3:0] pfl;
      logic [4:0] pst;
      logic [4:0] parent;
      logic [7:0] first;
      logic [2:0] okind;
      logic [4:0] ost;
      logic [7:0] last;
      logic [31:0] hx;
      logic [31:0] cp;
      logic [3:0] wl;
      logic [1:0] w;
      logic [4:0] wsel;
      s.res = nothing(ST_SUCCESS);
      s.top = top;
      s.st = st;
      s.hex = hex;
      s.wlen = wlen;
      s.pf = pf;
      s.push = 1'b0;
      s.parent = st;
      e = value_open(c, pf);
      want_eat = 1'b0;
      push_req = 1'b0;
      pop_req = 1'b0;
      pk = K_NONE;
      pfl = 4'd0;
      pst = S_START;
      parent = st;
      first = 8'd0;
      okind = K_NONE;
      ost = ST_SUCCESS;
      last = 8'd0;
      hx = 32'd0;
      cp = 32'd0;
      wl = 4'd0;
      wsel = st - S_FALSE;
      w = wsel[1:0];

      if (eoi) begin
         if ((top == STACK_AW'(1)) && NUM_END_MASK[st]) begin
            pop_req = 1'b1; okind = K_NUMBER; ost = ST_SUCCESS;
         end else begin
            s.res = nothing((st != S_START) ? ST_NO_DATA : ST_FAILURE);
         end
      end else if (is_ws(c) && (st <= S_MEM_NEXT)) begin
         s.res = nothing(ST_SUCCESS);
      end else begin
         unique case (st)
            S_START: want_eat = 1'b1;
            S_ELEM_FIRST: begin
               if (c == "]") begin
                  pop_req = 1'b1; okind = K_ARRAY;
               end else begin
                  want_eat = 1'b1; parent = S_ELEM_SEP;
               end
            end
            S_ELEM_SEP: begin
               if (c == "]") begin
                  pop_req = 1'b1; okind = K_ARRAY;
               end else if (c == ",") begin
                  s.st = S_ELEM_NEXT; s.pf = F_ELEMENT;
               end else begin
                  s.res = nothing(ST_EXP_COMMA);
               end
            end
            S_ELEM_NEXT, S_VALUE_START: begin
               want_eat = 1'b1;
               parent = (st == S_ELEM_NEXT) ? S_ELEM_SEP : S_MEM_SEP;
            end
            S_NAME_FIRST, S_MEM_NEXT: begin
               if ((st == S_NAME_FIRST) && (c == "}")) begin
                  pop_req = 1'b1; okind = K_OBJECT;
               end else if (c != 8'h22) begin
                  s.res = nothing(ST_EXP_QUOTE);
               end else begin
                  push_req = 1'b1; pk = K_STRING; pst = S_STR; parent = S_NAME_SEP;
                  pfl = (st == S_NAME_FIRST) ? (F_FIRST | F_MEM_NAME) : F_MEM_NAME;
               end
            end
            S_NAME_SEP: begin
               if (c == ":") begin
                  s.st = S_VALUE_START; s.pf = F_MEM_VALUE;
               end else begin
                  s.res = nothing(ST_EXP_COLON);
               end
            end
            S_MEM_SEP: begin
               if (c == ",") begin
                  s.st = S_MEM_NEXT; s.pf = 4'd0;
               end else if (c == "}") begin
                  pop_req = 1'b1; okind = K_OBJECT;
               end else begin
                  s.res = nothing(ST_EXP_COMMA);
               end
            end
            S_STR: begin
               if (c == 8'h22) begin
                  pop_req = 1'b1; okind = K_STRING;
               end else if (c == 8'h5C) begin
                  s.st = S_STR_ESC;
               end else if (c < 8'h20) begin
                  pop_req = 1'b1; okind = K_STRING; ost = ST_EXP_PRINTABLE;
               end else begin
                  s.res = one_byte(c);
               end
            end
            S_STR_ESC: begin
               s.st = S_STR;
               priority if ((c == 8'h22) || (c == "/") || (c == 8'h5C)) s.res = one_byte(c);
               else if (c == "b") s.res = one_byte(8'h08);
               else if (c == "f") s.res = one_byte(8'h0C);
               else if (c == "n") s.res = one_byte(8'h0A);
               else if (c == "r") s.res = one_byte(8'h0D);
               else if (c == "t") s.res = one_byte(8'h09);
               else if (c == "u") s.st = S_STR_HEX;
               else begin
                  s.st = st;
                  s.res = nothing(ST_EXP_ESCAPE);
               end
            end
            S_STR_HEX: begin
               if (!is_hex(c)) begin
                  s.res = nothing(ST_EXP_HEX);
               end else begin
                  hx = ((wlen != 4'd0) ? (hex << 4) : 32'd0) | {28'd0, nibble(c)};
                  wl = (wlen < 4'd15) ? wlen + 4'd1 : 4'd15;
                  s.hex = hx;
                  s.wlen = wl;
                  if (wl < 4'd4) begin
                     s.res = nothing(ST_SUCCESS);
                  end else if ((hx >= 32'hDC00) && (hx <= 32'hDFFF)) begin
                     s.res = nothing(ST_EXP_UTF16_HI);
                  end else if ((hx >= 32'hD800) && (hx <= 32'hDBFF)) begin
                     s.st = S_STR_LO;
                  end else begin
                     s.res = utf8_out(hx);
                     s.wlen = 4'd0;
                     s.st = S_STR;
                  end
               end
            end
            S_STR_LO: begin
               if (((wlen == 4'd4) && (c == 8'h5C)) || ((wlen == 4'd5) && (c == "u"))) begin
                  s.wlen = wlen + 4'd1;
               end else if (!is_hex(c)) begin
                  s.res = nothing(ST_EXP_HEX);
               end else begin
                  hx = (hex << 4) | {28'd0, nibble(c)};
                  wl = (wlen < 4'd15) ? wlen + 4'd1 : 4'd15;
                  s.hex = hx;
                  s.wlen = wl;
                  if (wl < 4'd10) begin
                     s.res = nothing(ST_SUCCESS);
                  end else if ((hx[15:0] < 16'hDC00) || (hx[15:0] > 16'hDFFF)) begin
                     s.res = nothing(ST_EXP_UTF16_LO);
                  end else begin
                     cp = (({16'd0, hx[31:16]} - 32'hD800) << 10)
                          + ({16'd0, hx[15:0]} - 32'hDC00) + 32'h10000;
                     s.res = utf8_out(cp);
                     s.wlen = 4'd0;
                     s.st = S_STR;
                  end
               end
            end
            S_INT_START: begin
               if (c == "0") begin
                  s.st = S_INT_END; s.res = one_byte(c);
               end else if (is_dig(c)) begin
                  s.st = S_INT_CONT; s.res = one_byte(c);
               end else begin
                  s.res = nothing(ST_EXP_DIGIT);
               end
            end
            S_INT_CONT, S_INT_END: begin
               if ((st == S_INT_CONT) && is_dig(c)) begin
                  s.res = one_byte(c);
               end else if (is_num_end(c)) begin
                  pop_req = 1'b1; okind = K_NUMBER; ost = ST_RETRY;
               end else if (c == ".") begin
                  s.st = S_FRAC_START; s.res = one_byte(c);
               end else if ((c == "E") || (c == "e")) begin
                  s.st = S_EXP_START; s.res = one_byte(c);
               end else begin
                  s.res = nothing(ST_EXP_DECIMAL);
               end
            end
            S_FRAC_START, S_EXP_INT_START: begin
               if (is_dig(c)) begin
                  s.st = (st == S_FRAC_START) ? S_FRAC_CONT : S_EXP_INT_CONT;
                  s.res = one_byte(c);
               end else begin
                  s.res = nothing(ST_EXP_DIGIT);
               end
            end
            S_FRAC_CONT: begin
               if (is_dig(c)) begin
                  s.res = one_byte(c);
               end else if ((c == "e") || (c == "E")) begin
                  s.st = S_EXP_START; s.res = one_byte(c);
               end else begin
                  pop_req = 1'b1; okind = K_NUMBER; ost = ST_RETRY;
               end
            end
            S_EXP_START: begin
               if ((c == "+") || (c == "-")) begin
                  s.st = S_EXP_INT_START; s.res = one_byte(c);
               end else if (is_dig(c)) begin
                  s.st = S_EXP_INT_CONT; s.res = one_byte(c);
               end else begin
                  s.res = nothing(ST_EXP_DIGIT);
               end
            end
            S_EXP_INT_CONT: begin
               if (is_dig(c)) begin
                  s.res = one_byte(c);
               end else begin
                  pop_req = 1'b1; okind = K_NUMBER;
                  ost = is_num_end(c) ? ST_RETRY : ST_EXP_DIGIT;
               end
            end
            S_FALSE, S_NULL, S_TRUE: begin
               if ((wlen >= lit_len(w)) || (c != lit_char(w, wlen))) begin
                  s.res = nothing(ST_EXP_LITERAL);
               end else begin
                  wl = wlen + 4'd1;
                  s.wlen = wl;
                  if (wl == lit_len(w)) begin
                     pop_req = 1'b1; okind = K_LITERAL; last = c;
                  end else begin
                     s.res = one_byte(c);
                  end
               end
            end
            default: s.res = nothing(ST_EXP_VALUE);
         endcase
      end

      if (want_eat) begin
         if (e.ok) begin
            push_req = 1'b1; pk = e.kind; pfl = e.flags; pst = e.state; first = e.first;
         end else begin
            s.res = nothing(ST_EXP_VALUE);
         end
      end

      if (push_req) begin
         if ((LIM_W'(top) + LIM_W'(1)) >= limit) begin
            s.res = nothing(ST_OVERFLOW);
         end else begin
            s.top = top + STACK_AW'(1);
            s.push = 1'b1;
            s.parent = parent;
            s.st = pst;
            s.pf = pfl;
            s.wlen = (first != 8'd0) ? 4'd1 : 4'd0;
            s.res = mk_res(ST_SUCCESS, EV_START, pk, pfl, first != 8'd0,
                           (first != 8'd0) ? 3'd1 : 3'd0, {24'd0, first});
         end
      end

      if (pop_req) begin
         s.res = mk_res(ST_UNDERFLOW, EV_END, okind, 4'd0, last != 8'd0,
                        (last != 8'd0) ? 3'd1 : 3'd0, {24'd0, last});
         if (top != '0) begin
            s.top = top - STACK_AW'(1);
            s.st = below;
            s.res.status = ost;
         end
         s.wlen = 4'd0;
         s.pf = 4'd0;
      end
      return s;
   endfunction

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_eoi_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   res_type             res_ff, res_in;
   logic [STACK_AW-1:0] top_ff, top_in;
   logic [4:0]          st_ff, st_in;
   logic [31:0]         hex_ff, hex_in;
   logic [3:0]          wlen_ff, wlen_in;
   logic [3:0]          pf_ff, pf_in;
   logic [6:0]          limit_ff, limit_in;
   logic [LIM_W-1:0]    limit;
   logic                fire;
   logic                retry;
   step_type            s1, s2, fin;
   logic [4:0]          rd_a, rd_b;
   logic [STACK_AW-1:0] next_top;

   assign fire = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || fire;
   assign csr_if.ready = 1'b1;
   assign limit = (LIM_W'(limit_ff) > LIM_W'(STACK_DEPTH)) ? LIM_W'(STACK_DEPTH)
                                                             : LIM_W'(limit_ff);

   always_comb begin
      s1 = lex_step(in_byte_ff, in_eoi_ff, top_ff, st_ff, rd_a, hex_ff, wlen_ff, pf_ff, limit);
      retry = (s1.res.status == ST_RETRY);
      // retried byte ended a number: it is lexed again in the parent state and may pop the container
      s2 = lex_step(in_byte_ff, in_eoi_ff, s1.top, s1.st, rd_b, s1.hex, s1.wlen, s1.pf, limit);
      fin = retry ? s2 : s1;
      res_in = s1.res;
      if (retry) begin
         res_in.status = s2.res.status;
         if (s2.res.event_res == EV_END) begin
            res_in.kind = s2.res.kind;
            res_in.event_res = EV_DOUBLE_END;
         end
      end
      if (!res_in.has_bytes) begin
         res_in.byte_count = 3'd0;
         res_in.out_bytes = 32'd0;
      end
      next_top = fire ? fin.top : top_ff;
      top_in = next_top;
      st_in = fire ? fin.st : st_ff;
      hex_in = fire ? fin.hex : hex_ff;
      wlen_in = fire ? fin.wlen : wlen_ff;
      pf_in = fire ? fin.pf : pf_ff;
      limit_in = (csr_if.valid && csr_if.ready) ? csr_if.data : limit_ff;
      in_valid_in = (req_if.valid && req_if.ready) || (in_valid_ff && !fire);
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_if.ready);
   end

   jsl_ram #(.WIDTH(5), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .we      (fire && s1.push),
      .waddr   (top_ff),
      .wdata   (s1.parent),
      .raddr_a (next_top - STACK_AW'(1)),
      .raddr_b (next_top - STACK_AW'(2)),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         top_ff <= '0;
         st_ff <= S_START;
         hex_ff <= 32'd0;
         wlen_ff <= 4'd0;
         pf_ff <= 4'd0;
         limit_ff <= 7'd64;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff <= top_in;
         st_ff <= st_in;
         hex_ff <= hex_in;
         wlen_ff <= wlen_in;
         pf_ff <= pf_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.in_byte;
         in_eoi_ff <= req_if.end_of_input;
      end
      if (fire) res_ff <= res_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = res_ff.status;
   assign rsp_if.event_res = res_ff.event_res;
   assign rsp_if.kind = res_ff.kind;
   assign rsp_if.is_first = res_ff.flags[0];
   assign rsp_if.is_element = res_ff.flags[1];
   assign rsp_if.is_member_name = res_ff.flags[2];
   assign rsp_if.is_member_value = res_ff.flags[3];
   assign rsp_if.has_bytes = res_ff.has_bytes;
   assign rsp_if.byte_count = res_ff.byte_count;
   assign rsp_if.out_bytes = res_ff.out_bytes;
endmodule

// ----- rtl/core/jsl_checker.sv -----
// jsl_checker: port-level assertions on the lexer result channel, bound to the top level.
// Depends on jsl_pkg.
module jsl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  status,
   input logic [2:0]  event_res,
   input logic        has_bytes,
   input logic [2:0]  byte_count,
   input logic [31:0] out_bytes
);
   import jsl_pkg::*;

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_bytes) && $stable(status))
      else $error("stalled result changed");

   a_no_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_bytes |-> (byte_count == 3'd0) && (out_bytes == 32'd0))
      else $error("byte payload without has_bytes");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && has_bytes |-> (byte_count != 3'd0) && (byte_count <= 3'd4))
      else $error("bad byte count");

   // a push is only reported when it succeeded
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_res == EV_START) |-> (status == ST_SUCCESS))
      else $error("start event with error status");
endmodule

bind json_stream_lexer jsl_checker u_jsl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .status     (rsp_if.status),
   .event_res  (rsp_if.event_res),
   .has_bytes  (rsp_if.has_bytes),
   .byte_count (rsp_if.byte_count),
   .out_bytes  (rsp_if.out_bytes)
);
